/* src/prbs_pkg.sv */
// ----------------------------------------------------------------------------
// prbs_pkg
// Shared types, constants and the tap mask table of the prbs generator.
// ----------------------------------------------------------------------------
package prbs_pkg;

    localparam int MAX_LENGTH_DEF = 64;
    localparam int LEN_W          = 7;
    localparam int SEED_W         = 32;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;
    localparam int TAP_W          = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 1'd1;

    // controls shared by every cell of the chain
    typedef struct packed {
        logic step;
        logic reload;
        logic top;
    } t_cell_ctrl;

    function automatic logic [TAP_W-1:0] tap_mask(input logic [LEN_W-1:0] len);
        logic [TAP_W-1:0] m;
        case (len)
            7'd5:    m = 64'd2;
            7'd8:    m = 64'd14;
            7'd9:    m = 64'd8;
            7'd10:   m = 64'd4;
            7'd11:   m = 64'd2;
            7'd12:   m = 64'd41;
            7'd13:   m = 64'd13;
            7'd14:   m = 64'd21;
            7'd16:   m = 64'd20488;
            7'd17:   m = 64'd8192;
            7'd18:   m = 64'd132096;
            7'd19:   m = 64'd35;
            7'd20:   m = 64'd65536;
            7'd21:   m = 64'd262144;
            7'd22:   m = 64'd1048576;
            7'd23:   m = 64'd131072;
            7'd24:   m = 64'd6356992;
            7'd25:   m = 64'd2097152;
            7'd26:   m = 64'd35;
            7'd27:   m = 64'd19;
            7'd28:   m = 64'd16777216;
            7'd29:   m = 64'd67108864;
            7'd30:   m = 64'd41;
            7'd31:   m = 64'd134217728;
            7'd32:   m = 64'd2097155;
            7'd33:   m = 64'd524288;
            7'd34:   m = 64'd67108867;
            7'd35:   m = 64'd4294967296;
            7'd36:   m = 64'd16777216;
            7'd37:   m = 64'd31;
            7'd38:   m = 64'd49;
            7'd39:   m = (64'd1 << 34);
            7'd40:   m = (64'd1 << 37) | (64'd1 << 20) | (64'd1 << 18);
            7'd41:   m = (64'd1 << 37);
            7'd42:   m = (64'd1 << 40) | (64'd1 << 19) | (64'd1 << 18);
            7'd43:   m = (64'd1 << 41) | (64'd1 << 37) | (64'd1 << 36);
            7'd44:   m = (64'd1 << 42) | (64'd1 << 17) | (64'd1 << 16);
            7'd45:   m = (64'd1 << 43) | (64'd1 << 41) | (64'd1 << 40);
            7'd46:   m = (64'd1 << 44) | (64'd1 << 25) | (64'd1 << 24);
            7'd47:   m = (64'd1 << 41);
            7'd48:   m = (64'd1 << 46) | (64'd1 << 20) | (64'd1 << 19);
            7'd49:   m = (64'd1 << 39);
            7'd50:   m = (64'd1 << 48) | (64'd1 << 23) | (64'd1 << 22);
            7'd51:   m = (64'd1 << 49) | (64'd1 << 35) | (64'd1 << 34);
            7'd52:   m = (64'd1 << 48);
            7'd53:   m = (64'd1 << 51) | (64'd1 << 37) | (64'd1 << 36);
            7'd54:   m = (64'd1 << 52) | (64'd1 << 17) | (64'd1 << 16);
            7'd55:   m = (64'd1 << 30);
            7'd56:   m = (64'd1 << 54) | (64'd1 << 34) | (64'd1 << 33);
            7'd57:   m = (64'd1 << 48) | (64'd1 << 23) | (64'd1 << 22);
            7'd58:   m = (64'd1 << 49);
            7'd59:   m = (64'd1 << 57) | (64'd1 << 37) | (64'd1 << 36);
            7'd60:   m = (64'd1 << 58);
            7'd61:   m = (64'd1 << 59) | (64'd1 << 45) | (64'd1 << 44);
            7'd62:   m = (64'd1 << 60) | (64'd1 << 5) | (64'd1 << 4);
            7'd63:   m = (64'd1 << 61);
            7'd64:   m = (64'd1 << 62) | (64'd1 << 60) | (64'd1 << 59);
            default: m = 64'd1;
        endcase
        return m;
    endfunction

endpackage

/* src/prbs_cell.sv */
// ----------------------------------------------------------------------------
// prbs_cell
// One bit of the shift register: takes its neighbor's bit, xors in a tap.
// ----------------------------------------------------------------------------
module prbs_cell
    import prbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_seed_bit,
    input  logic       i_keep,
    input  logic       i_tap,
    input  logic       i_prev_bit,
    output logic       o_bit
);

    logic r_bit;
    logic n_bit;

    // bit as seen by this step: seed on reload, cleared above the length
    assign o_bit = i_keep & (i_ctrl.reload ? i_seed_bit : r_bit);
    assign n_bit = i_keep & (i_prev_bit ^ (i_ctrl.top & i_tap));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctrl.step) begin
            r_bit <= n_bit;
        end
    end

endmodule

/* src/prbs_galois_lfsr_generator.sv */
// ----------------------------------------------------------------------------
// prbs_galois_lfsr_generator
// Galois shift register pattern generator built as a chain of one-bit cells.
// ----------------------------------------------------------------------------
// Every accepted input word yields one output word with the register's top
// bit and a copy of the last flag. One word is taken per clock while the
// output is not stalled, the shift of all cells being done in the cycle the
// word is accepted. While a result waits in the output register the input
// is held off, and a new word is taken in the same cycle the waiting result
// is read out. The result is registered and shows in the next cycle.
// The register length (clamped to 1..MAX_LENGTH) selects the tap mask; the
// first word after reset or after a word flagged last restarts from the seed.
module prbs_galois_lfsr_generator
    import prbs_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_last_of_pattern,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_pattern_bit,
    output logic                  o_last_bit
);

    localparam int IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

    logic [LEN_W-1:0]      r_length;
    logic [SEED_W-1:0]     r_seed;
    logic                  r_reload;
    logic                  r_out_valid;
    logic                  r_pattern_bit;
    logic                  r_last_bit;

    logic                  w_accept;
    logic [LEN_W-1:0]      w_len;
    logic [IDX_W-1:0]      w_top_idx;
    logic [TAP_W-1:0]      w_tap_full;
    logic [MAX_LENGTH-1:0] w_tap_in;
    logic [MAX_LENGTH-1:0] w_keep;
    logic [MAX_LENGTH-1:0] w_seed;
    logic [MAX_LENGTH-1:0] w_eff;
    logic [MAX_LENGTH-1:0] w_prev;
    logic                  w_top;
    t_cell_ctrl            w_ctrl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= LEN_W'(7);
            r_seed   <= SEED_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LENGTH: r_length <= i_cfg_data[LEN_W-1:0];
                REG_SEED:   r_seed   <= i_cfg_data[SEED_W-1:0];
                default:    ;
            endcase
        end
    end

    // effective length: zero acts as one, large values saturate
    always_comb begin
        if (r_length == '0) begin
            w_len = LEN_W'(1);
        end else if (r_length > LEN_W'(MAX_LENGTH)) begin
            w_len = LEN_W'(MAX_LENGTH);
        end else begin
            w_len = r_length;
        end
    end

    assign w_top_idx  = IDX_W'(w_len - LEN_W'(1));
    assign w_tap_full = tap_mask(w_len);
    // cell 0 takes the top bit as its fill-in
    assign w_tap_in   = {w_tap_full[MAX_LENGTH-2:0], 1'b1};
    assign w_prev     = {w_eff[MAX_LENGTH-2:0], 1'b0};
    assign w_top      = w_eff[w_top_idx];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_ctrl.step   = w_accept;
    assign w_ctrl.reload = r_reload;
    assign w_ctrl.top    = w_top;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LENGTH; gi++) begin : g_cell
            assign w_keep[gi] = (LEN_W'(gi) < w_len);
            if (gi < SEED_W) begin : g_seed
                assign w_seed[gi] = r_seed[gi];
            end else begin : g_zero
                assign w_seed[gi] = 1'b0;
            end
            prbs_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_seed_bit (w_seed[gi]),
                .i_keep     (w_keep[gi]),
                .i_tap      (w_tap_in[gi]),
                .i_prev_bit (w_prev[gi]),
                .o_bit      (w_eff[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_reload <= i_last_of_pattern;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pattern_bit <= w_top;
            r_last_bit    <= i_last_of_pattern;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pattern_bit = r_pattern_bit;
    assign o_last_bit    = r_last_bit;

endmodule

/* tb/prbs_galois_lfsr_generator_tb.sv */
// ----------------------------------------------------------------------------
// prbs_galois_lfsr_generator_tb
// Self-checking bench for the Galois shift register pattern generator: words
// are sent through valid/ready with random gaps on both sides, each result is
// compared with a local model of the register, and register writes sweep the
// length (clamped values too) and seed between phases.
// ----------------------------------------------------------------------------
module prbs_galois_lfsr_generator_tb;
    import prbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_CAP = MAX_LENGTH_DEF;

    typedef struct packed {
        logic pattern_bit;
        logic last_bit;
    } prbs_word_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_last_of_pattern;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_pattern_bit;
    logic                  o_last_bit;

    // model of the generator
    logic [LEN_W-1:0]  len_cfg;
    logic [SEED_W-1:0] seed_cfg;
    logic [63:0]       lfsr_model;
    logic              reload_due;

    prbs_word_t expected_bits[$];

    int send_idle_pct;
    int recv_idle_pct;
    int stall_left;
    int words_sent;
    int words_checked;
    int patterns_sent;
    int cfg_writes;
    int mismatches;

    prbs_galois_lfsr_generator DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_last_of_pattern (i_last_of_pattern),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_pattern_bit     (o_pattern_bit),
        .o_last_bit        (o_last_bit)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] feedback_taps(input int unsigned n);
        logic [63:0] t;
        case (n)
            5, 11:   t = 64'd2;
            8:       t = 64'd14;
            9:       t = 64'd8;
            10:      t = 64'd4;
            12, 30:  t = 64'd41;
            13:      t = 64'd13;
            14:      t = 64'd21;
            16:      t = 64'd20488;
            17:      t = 64'd8192;
            18:      t = 64'd132096;
            19, 26:  t = 64'd35;
            20:      t = 64'd65536;
            21:      t = 64'd262144;
            22:      t = 64'd1048576;
            23:      t = 64'd131072;
            24:      t = 64'd6356992;
            25:      t = 64'd2097152;
            27:      t = 64'd19;
            28, 36:  t = 64'd16777216;
            29:      t = 64'd67108864;
            31:      t = 64'd134217728;
            32:      t = 64'd2097155;
            33:      t = 64'd524288;
            34:      t = 64'd67108867;
            35:      t = 64'd4294967296;
            37:      t = 64'd31;
            38:      t = 64'd49;
            39:      t = 64'd1 << 34;
            40:      t = (64'd1 << 37) | (64'd1 << 20) | (64'd1 << 18);
            41:      t = 64'd1 << 37;
            42:      t = (64'd1 << 40) | (64'd1 << 19) | (64'd1 << 18);
            43:      t = (64'd1 << 41) | (64'd1 << 37) | (64'd1 << 36);
            44:      t = (64'd1 << 42) | (64'd1 << 17) | (64'd1 << 16);
            45:      t = (64'd1 << 43) | (64'd1 << 41) | (64'd1 << 40);
            46:      t = (64'd1 << 44) | (64'd1 << 25) | (64'd1 << 24);
            47:      t = 64'd1 << 41;
            48:      t = (64'd1 << 46) | (64'd1 << 20) | (64'd1 << 19);
            49:      t = 64'd1 << 39;
            50, 57:  t = (64'd1 << 48) | (64'd1 << 23) | (64'd1 << 22);
            51:      t = (64'd1 << 49) | (64'd1 << 35) | (64'd1 << 34);
            52:      t = 64'd1 << 48;
            53:      t = (64'd1 << 51) | (64'd1 << 37) | (64'd1 << 36);
            54:      t = (64'd1 << 52) | (64'd1 << 17) | (64'd1 << 16);
            55:      t = 64'd1 << 30;
            56:      t = (64'd1 << 54) | (64'd1 << 34) | (64'd1 << 33);
            58:      t = 64'd1 << 49;
            59:      t = (64'd1 << 57) | (64'd1 << 37) | (64'd1 << 36);
            60:      t = 64'd1 << 58;
            61:      t = (64'd1 << 59) | (64'd1 << 45) | (64'd1 << 44);
            62:      t = (64'd1 << 60) | (64'd1 << 5) | (64'd1 << 4);
            63:      t = 64'd1 << 61;
            64:      t = (64'd1 << 62) | (64'd1 << 60) | (64'd1 << 59);
            default: t = 64'd1;
        endcase
        return t;
    endfunction

    function automatic int unsigned active_length();
        int unsigned n;
        n = len_cfg;
        if (n < 1) n = 1;
        if (n > LEN_CAP) n = LEN_CAP;
        return n;
    endfunction

    // one shift of the modeled register, returns the word the block should emit
    function automatic prbs_word_t advance_prbs(input logic last);
        int unsigned n;
        logic [63:0] keep;
        prbs_word_t w;
        n    = active_length();
        keep = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        if (reload_due) lfsr_model = {32'd0, seed_cfg};
        lfsr_model &= keep;
        w.pattern_bit = lfsr_model[n-1];
        if (w.pattern_bit) lfsr_model = ((lfsr_model ^ feedback_taps(n)) << 1) | 64'd1;
        else lfsr_model = lfsr_model << 1;
        lfsr_model &= keep;
        reload_due = last;
        w.last_bit = last;
        return w;
    endfunction

    task automatic send_word(input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_last_of_pattern <= last;
        do @(posedge i_clk); while (!o_in_ready);
        expected_bits.push_back(advance_prbs(last));
        words_sent++;
        if (last) patterns_sent++;
    endtask

    // drop valid and wait until every word sent has come back
    task automatic drain_words();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_bits.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_LENGTH) len_cfg = data[LEN_W-1:0];
        else if (idx == REG_SEED) seed_cfg = data;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pattern(input int count, input bit close);
        for (int k = 0; k < count; k++) send_word(close && (k == count - 1));
    endtask

    // receiver side: long hold-off first, otherwise random stalls
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        prbs_word_t exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word bit=%b last=%b", $realtime,
                             o_pattern_bit, o_last_bit);
            end else begin
                exp_w = expected_bits.pop_front();
                words_checked++;
                if (o_pattern_bit !== exp_w.pattern_bit || o_last_bit !== exp_w.last_bit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: word %0d bit exp %b got %b, last exp %b got %b",
                                 $realtime, words_checked, exp_w.pattern_bit, o_pattern_bit,
                                 exp_w.last_bit, o_last_bit);
                end
            end
        end
    end

    task automatic test_reset_values();
        // length 7, seed 1 straight out of reset
        send_pattern(5, 1);
        drain_words();
    endtask

    task automatic test_length_extremes();
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        write_reg(REG_LENGTH, 32'd0);            // zero behaves as one
        send_pattern(2, 1);
        drain_words();
        write_reg(REG_LENGTH, 32'hFFFF_FF7F);    // 127 saturates to the cap
        send_pattern(3, 1);
        drain_words();
        write_reg(REG_LENGTH, 32'd1);
        write_reg(REG_SEED, 32'd1);
        send_pattern(3, 1);
        drain_words();
        write_reg(REG_LENGTH, 32'd64);
        write_reg(REG_SEED, 32'h8000_0001);
        send_pattern(2, 1);
        drain_words();
    endtask

    task automatic test_seed_truncation();
        write_reg(REG_LENGTH, 32'd3);
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        send_pattern(3, 1);
        drain_words();
    endtask

    task automatic test_length_change_mid_pattern();
        write_reg(REG_LENGTH, 32'd16);
        write_reg(REG_SEED, 32'h0000_ACE1);
        send_pattern(3, 0);
        drain_words();
        // register continues, cut to the new length
        write_reg(REG_LENGTH, 32'd5);
        send_pattern(4, 1);
        drain_words();
    endtask

    task automatic random_phase();
        logic [LEN_W-1:0] len;
        logic [31:0]      seed;
        int               nwords;
        int               odds;
        case ($urandom_range(9))
            0:       len = 7'd0;
            1:       len = 7'($urandom_range(127, 65));
            default: len = 7'($urandom_range(64, 1));
        endcase
        case ($urandom_range(7))
            0:       seed = 32'd0;
            1:       seed = 32'hFFFF_FFFF;
            default: seed = $urandom;
        endcase
        if ($urandom_range(3) != 0) write_reg(REG_SEED, seed);
        write_reg(REG_LENGTH, ($urandom & 32'hFFFF_FF80) | 32'(len));
        // long registers need long patterns before the seed reaches the top
        odds   = (len > 16) ? 47 : 11;
        nwords = $urandom_range(60, 20);
        for (int k = 0; k < nwords; k++) begin
            if ($urandom_range(19) == 0) send_word(1'b1);       // stray early end
            else send_word($urandom_range(odds) == 0);
        end
        drain_words();
    endtask

    task automatic test_random_patterns(input int target);
        int start;
        start = words_sent;
        while (words_sent - start < target) random_phase();
    endtask

    task automatic test_backpressure();
        write_reg(REG_LENGTH, 32'd23);
        write_reg(REG_SEED, $urandom);
        @(posedge i_clk);
        stall_left = 300;
        send_pattern(12, 0);
        drain_words();
        // idle gap with the pattern still open, then carry on
        send_pattern(10, 1);
        drain_words();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = REG_LENGTH;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_last_of_pattern = 1'b0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        stall_left        = 0;
        words_sent        = 0;
        words_checked     = 0;
        patterns_sent     = 0;
        cfg_writes        = 0;
        mismatches        = 0;
        len_cfg           = 7'd7;
        seed_cfg          = 32'd1;
        lfsr_model        = '0;
        reload_due        = 1'b1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 78;
        test_reset_values();
        test_length_extremes();
        test_seed_truncation();
        test_length_change_mid_pattern();
        test_random_patterns(150);
        test_backpressure();

        send_idle_pct = 78;
        recv_idle_pct = 29;
        test_random_patterns(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_patterns(150);

        drain_words();
        repeat (10) @(posedge i_clk);
        $display("checked %0d of %0d words in %0d closed patterns, %0d register writes",
                 words_checked, words_sent, patterns_sent, cfg_writes);
        $display("lengths 0 to 127 with clamping, zero and full seeds, long output stall");
        if (mismatches == 0) begin
            $display("prbs_galois_lfsr_generator_tb OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("prbs_galois_lfsr_generator_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d words outstanding", expected_bits.size());
        $display("prbs_galois_lfsr_generator_tb NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
src/prbs_pkg.sv
src/prbs_cell.sv
src/prbs_galois_lfsr_generator.sv
tb/prbs_galois_lfsr_generator_tb.sv
